// ===== src/mfto_pkg.sv =====
`default_nettype none
package mfto_pkg;

  typedef logic [1:0] cmd_t;
  typedef logic [2:0] status_t;

  localparam cmd_t CMD_CLEAR    = 2'd0;
  localparam cmd_t CMD_START    = 2'd1;
  localparam cmd_t CMD_CONTINUE = 2'd2;
  localparam cmd_t CMD_POP      = 2'd3;

  localparam status_t ST_OK       = 3'd0;
  localparam status_t ST_FULL     = 3'd1;
  localparam status_t ST_COMPLETE = 3'd2;
  localparam status_t ST_CYCLE    = 3'd3;
  localparam status_t ST_RANGE    = 3'd4;

  localparam int NODE_W  = 10;
  localparam int COUNT_W = 11;

  localparam int MAX_NODES = 1024;
  localparam int MAX_EDGES = 4096;

endpackage
`default_nettype wire

// ===== src/min_first_topological_order.sv =====
`default_nettype none
// Channel   | Ports                               | Handshake
// ----------+-------------------------------------+----------------------------------
// input     | start, in_cmd, in_node, busy        | word taken when start & !busy
// result    | out_valid, out_node, out_status     | one-cycle strobe, no back-pressure
// config    | cfg_wr_en, cfg_wr_data              | node_count written when cfg_wr_en
//
// What each command does before the next word can be taken:
// chain start leaves busy low; chain continue reads head and in-degree, then writes.
// Pop scans the node store, read through its one read port, one entry a cycle up to
// the first ready node, then walks each successor with an edge read, an in-degree
// read and a write back; with nothing ready it scans all count entries and reports.
// Clear wipes all MAX_NODES node entries, one node entry a cycle.
// After reset the same clearing pass runs with busy high and no
// result word. Results cannot be stalled: each appears for one cycle only.
module min_first_topological_order
  import mfto_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         in_cmd,
  input  wire logic [NODE_W-1:0]  in_node,
  output logic                    out_valid,
  output logic [NODE_W-1:0]       out_node,
  output logic [2:0]              out_status,
  input  wire logic               cfg_wr_en,
  input  wire logic [COUNT_W-1:0] cfg_wr_data
);

  localparam int NW  = $clog2(MAX_NODES);
  localparam int CW  = $clog2(MAX_NODES + 1);
  localparam int KW  = (CW > COUNT_W) ? CW : COUNT_W;
  localparam int ETW = $clog2(MAX_EDGES + 1);
  localparam int AW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int DW  = ETW;

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_CWR   = 4'd2;
  localparam logic [3:0] S_SCAN  = 4'd3;
  localparam logic [3:0] S_MARK  = 4'd4;
  localparam logic [3:0] S_HEAD  = 4'd5;
  localparam logic [3:0] S_EDGE  = 4'd6;
  localparam logic [3:0] S_TGT   = 4'd7;
  localparam logic [3:0] S_DEC   = 4'd8;

  logic [3:0]     state_r, state_nxt;
  logic [KW-1:0]  node_count_r;
  logic [NW-1:0]  clr_i_r, clr_i_nxt;
  logic           clr_rep_r, clr_rep_nxt;
  logic [ETW-1:0] edge_total_r, edge_total_nxt;
  logic [NW-1:0]  chain_prev_r, chain_prev_nxt;
  logic [NW-1:0]  cnode_r, cnode_nxt;
  logic [KW-1:0]  scan_i_r, scan_i_nxt;
  logic [NW-1:0]  chk_i_r, chk_i_nxt;
  logic           chk_v_r, chk_v_nxt;
  logic           pending_r, pending_nxt;
  logic [NW-1:0]  pick_r, pick_nxt;
  logic [ETW-1:0] e_r, e_nxt;
  logic [NW-1:0]  tgt_r, tgt_nxt;
  logic           ov_r, ov_nxt;
  logic [NODE_W-1:0] on_r, on_nxt;
  logic [2:0]     os_r, os_nxt;

  // node store: {emitted, in_degree}
  logic          nm_we;
  logic [NW-1:0] nm_wa, nm_ra;
  logic [DW:0]   nm_wd, nm_rd;
  // list heads
  logic           hm_we;
  logic [NW-1:0]  hm_wa, hm_ra;
  logic [ETW-1:0] hm_wd, hm_rd;
  // edges: {target, next}
  logic              em_we;
  logic [AW-1:0]     em_wa, em_ra;
  logic [NW+ETW-1:0] em_wd, em_rd;

  logic [KW-1:0] count;
  logic          node_bad;

  mfto_ram #(.WIDTH(DW + 1), .DEPTH(MAX_NODES), .AW(NW)) u_node_ram (
    .clk(clk), .we(nm_we), .waddr(nm_wa), .wdata(nm_wd), .raddr(nm_ra), .rdata(nm_rd)
  );
  mfto_ram #(.WIDTH(ETW), .DEPTH(MAX_NODES), .AW(NW)) u_head_ram (
    .clk(clk), .we(hm_we), .waddr(hm_wa), .wdata(hm_wd), .raddr(hm_ra), .rdata(hm_rd)
  );
  mfto_ram #(.WIDTH(NW + ETW), .DEPTH(MAX_EDGES), .AW(AW)) u_edge_ram (
    .clk(clk), .we(em_we), .waddr(em_wa), .wdata(em_wd), .raddr(em_ra), .rdata(em_rd)
  );

  assign count = (node_count_r > KW'(MAX_NODES)) ? KW'(MAX_NODES) : node_count_r;
  assign busy       = (state_r != S_IDLE);
  assign out_valid  = ov_r;
  assign out_node   = on_r;
  assign out_status = os_r;

  always_comb begin
    state_nxt      = state_r;
    clr_i_nxt      = clr_i_r;
    clr_rep_nxt    = clr_rep_r;
    edge_total_nxt = edge_total_r;
    chain_prev_nxt = chain_prev_r;
    cnode_nxt      = cnode_r;
    scan_i_nxt     = scan_i_r;
    chk_i_nxt      = chk_i_r;
    chk_v_nxt      = 1'b0;
    pending_nxt    = pending_r;
    pick_nxt       = pick_r;
    e_nxt          = e_r;
    tgt_nxt        = tgt_r;
    ov_nxt         = 1'b0;
    on_nxt         = '0;
    os_nxt         = ST_OK;
    node_bad       = 1'b0;

    nm_we = 1'b0; nm_wa = '0; nm_wd = '0; nm_ra = '0;
    hm_we = 1'b0; hm_wa = '0; hm_wd = '0; hm_ra = '0;
    em_we = 1'b0; em_wa = edge_total_r[AW-1:0]; em_wd = '0; em_ra = e_r[AW-1:0];

    case (state_r)
      S_CLR: begin
        // wipe one node entry a cycle
        nm_we = 1'b1; nm_wa = clr_i_r; nm_wd = '0;
        hm_we = 1'b1; hm_wa = clr_i_r; hm_wd = ETW'(MAX_EDGES);
        clr_i_nxt = clr_i_r + NW'(1);
        if (clr_i_r == NW'(MAX_NODES - 1)) begin
          clr_i_nxt   = '0;
          state_nxt   = S_IDLE;
          ov_nxt      = clr_rep_r;
          clr_rep_nxt = 1'b0;
        end
      end
      S_IDLE: begin
        hm_ra = chain_prev_r;
        nm_ra = in_node[NW-1:0];
        if (start) begin
          node_bad = (KW'(in_node) >= count);
          case (in_cmd)
            CMD_CLEAR: begin
              edge_total_nxt = '0;
              chain_prev_nxt = '0;
              clr_rep_nxt    = 1'b1;
              state_nxt      = S_CLR;
            end
            CMD_START: begin
              ov_nxt = 1'b1;
              if (node_bad) begin
                os_nxt = ST_RANGE;
              end else begin
                chain_prev_nxt = in_node[NW-1:0];
              end
            end
            CMD_CONTINUE: begin
              if (node_bad || (KW'(chain_prev_r) >= count)) begin
                ov_nxt = 1'b1; os_nxt = ST_RANGE;
              end else if (edge_total_r == ETW'(MAX_EDGES)) begin
                ov_nxt = 1'b1; os_nxt = ST_FULL;
              end else begin
                cnode_nxt = in_node[NW-1:0];
                state_nxt = S_CWR;
              end
            end
            default: begin
              scan_i_nxt  = '0;
              pending_nxt = 1'b0;
              state_nxt   = S_SCAN;
            end
          endcase
        end
      end
      S_CWR: begin
        // link the new edge at the head of the source's list
        em_we = 1'b1;
        em_wd = {cnode_r, hm_rd};
        hm_we = 1'b1; hm_wa = chain_prev_r; hm_wd = edge_total_r;
        nm_we = 1'b1; nm_wa = cnode_r;
        nm_wd = {nm_rd[DW], nm_rd[DW-1:0] + DW'(1)};
        edge_total_nxt = edge_total_r + ETW'(1);
        chain_prev_nxt = cnode_r;
        ov_nxt    = 1'b1;
        state_nxt = S_IDLE;
      end
      S_SCAN: begin
        nm_ra = scan_i_r[NW-1:0];
        if (scan_i_r < count) begin
          chk_v_nxt  = 1'b1;
          chk_i_nxt  = scan_i_r[NW-1:0];
          scan_i_nxt = scan_i_r + KW'(1);
        end
        if (chk_v_r && !nm_rd[DW]) begin
          pending_nxt = 1'b1;
          if (nm_rd[DW-1:0] == '0) begin
            pick_nxt  = chk_i_r;
            chk_v_nxt = 1'b0;
            state_nxt = S_MARK;
          end
        end
        if (!chk_v_r && scan_i_r >= count) begin
          ov_nxt    = 1'b1;
          os_nxt    = pending_r ? ST_CYCLE : ST_COMPLETE;
          state_nxt = S_IDLE;
        end
      end
      S_MARK: begin
        nm_we = 1'b1; nm_wa = pick_r; nm_wd = {1'b1, DW'(0)};
        hm_ra = pick_r;
        state_nxt = S_HEAD;
      end
      S_HEAD: begin
        e_nxt     = hm_rd;
        state_nxt = S_EDGE;
      end
      S_EDGE: begin
        em_ra = e_r[AW-1:0];
        if (e_r >= edge_total_r) begin
          ov_nxt    = 1'b1;
          on_nxt    = NODE_W'(pick_r);
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_TGT;
        end
      end
      S_TGT: begin
        tgt_nxt   = em_rd[NW+ETW-1:ETW];
        e_nxt     = em_rd[ETW-1:0];
        nm_ra     = em_rd[NW+ETW-1:ETW];
        state_nxt = S_DEC;
      end
      S_DEC: begin
        // floor at zero
        nm_we = 1'b1; nm_wa = tgt_r;
        nm_wd = {nm_rd[DW], (nm_rd[DW-1:0] == '0) ? DW'(0) : nm_rd[DW-1:0] - DW'(1)};
        state_nxt = S_EDGE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLR;
      node_count_r <= KW'(1024);
      clr_i_r      <= '0;
      clr_rep_r    <= 1'b0;
      edge_total_r <= '0;
      chain_prev_r <= '0;
      chk_v_r      <= 1'b0;
      pending_r    <= 1'b0;
      ov_r         <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      if (cfg_wr_en) begin
        node_count_r <= KW'(cfg_wr_data);
      end
      clr_i_r      <= clr_i_nxt;
      clr_rep_r    <= clr_rep_nxt;
      edge_total_r <= edge_total_nxt;
      chain_prev_r <= chain_prev_nxt;
      chk_v_r      <= chk_v_nxt;
      pending_r    <= pending_nxt;
      ov_r         <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnode_r  <= cnode_nxt;
    scan_i_r <= scan_i_nxt;
    chk_i_r  <= chk_i_nxt;
    pick_r   <= pick_nxt;
    e_r      <= e_nxt;
    tgt_r    <= tgt_nxt;
    on_r     <= on_nxt;
    os_r     <= os_nxt;
  end

endmodule
`default_nettype wire

// ===== src/mfto_ram.sv =====
`default_nettype none
module mfto_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== bench/tb_min_first_topological_order.sv =====
`timescale 1ns / 1ps
module tb_min_first_topological_order
  import mfto_pkg::*;
();

  localparam int NODES     = MAX_NODES;
  localparam int EDGES     = MAX_EDGES;
  localparam int LIST_END  = EDGES;   // empty successor list marker
  localparam int WD_LIMIT  = 200000;  // worst pop: full node scan plus the walk over every edge
  localparam int ITEMS     = 1550;

  // directed rows either send a command word or rewrite node_count
  typedef enum logic {ROW_WORD, ROW_CFG} row_kind_t;
  typedef struct packed {
    row_kind_t   kind;
    cmd_t        cmd;
    logic [10:0] arg;
    logic        typed;
    logic [9:0]  exp_node;
    status_t     exp_st;
  } dir_row_t;

  typedef struct packed {
    logic [9:0] node;
    status_t    st;
  } word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  cmd_t in_cmd = CMD_CLEAR;
  logic [NODE_W-1:0] in_node = '0;
  logic out_valid;
  logic [NODE_W-1:0] out_node;
  logic [2:0] out_status;
  logic cfg_wr_en = 1'b0;
  logic [COUNT_W-1:0] cfg_wr_data = '0;

  min_first_topological_order DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_cmd(in_cmd), .in_node(in_node),
    .out_valid(out_valid), .out_node(out_node), .out_status(out_status),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow copy of the graph store, kept in step with every accepted word
  int unsigned in_deg [NODES];
  int unsigned head [NODES];
  int unsigned edge_to [EDGES];
  int unsigned edge_link [EDGES];
  int unsigned edge_cnt;
  bit          done_mark [NODES];
  int unsigned chain_last;
  int unsigned node_count;

  word_t expected_words [$];
  int    errors = 0;
  int    words_sent = 0;
  bit    quiet = 1'b0;   // no idling while set

  function automatic void wipe_graph();
    for (int i = 0; i < NODES; i++) begin
      in_deg[i] = 0;
      head[i] = LIST_END;
      done_mark[i] = 1'b0;
    end
    edge_cnt = 0;
    chain_last = 0;
  endfunction

  // Work out the result word of one command and advance the shadow graph
  function automatic word_t order_step(cmd_t cmd, int unsigned nd);
    word_t w;
    int unsigned live;
    int unsigned e;
    int unsigned steps;
    int    pick;
    bit    pending;
    w = '{node: '0, st: ST_OK};
    live = (node_count > NODES) ? NODES : node_count;
    case (cmd)
      CMD_CLEAR: begin
        wipe_graph();
      end
      CMD_START: begin
        if (nd >= live) w.st = ST_RANGE;
        else chain_last = nd;
      end
      CMD_CONTINUE: begin
        if (nd >= live || chain_last >= live) w.st = ST_RANGE;
        else if (edge_cnt >= EDGES) w.st = ST_FULL;
        else begin
          edge_to[edge_cnt] = nd;
          edge_link[edge_cnt] = head[chain_last];
          head[chain_last] = edge_cnt;
          edge_cnt++;
          in_deg[nd]++;
          chain_last = nd;
        end
      end
      default: begin
        // lowest ready node wins; release its successors
        pick = -1;
        pending = 1'b0;
        for (int i = 0; i < live; i++) begin
          if (!done_mark[i]) begin
            pending = 1'b1;
            if (in_deg[i] == 0) begin
              pick = i;
              break;
            end
          end
        end
        if (pick >= 0) begin
          done_mark[pick] = 1'b1;
          e = head[pick];
          steps = 0;
          while (e < edge_cnt && steps < EDGES) begin
            if (in_deg[edge_to[e]] > 0) in_deg[edge_to[e]]--;
            e = edge_link[e];
            steps++;
          end
          w.node = pick[9:0];
        end else begin
          w.st = pending ? ST_CYCLE : ST_COMPLETE;
        end
      end
    endcase
    return w;
  endfunction

  // Present one word from a falling edge until it is taken; predict on acceptance.
  // An optional idle gap comes first; start is lowered only when the gap is taken.
  task automatic send_word(cmd_t cmd, int unsigned nd, bit typed, word_t typed_w);
    word_t w;
    if (!quiet && $urandom_range(99) < 15) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    start <= 1'b1;
    in_cmd <= cmd;
    in_node <= nd[9:0];
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    w = order_step(cmd, nd);
    expected_words.insert(expected_words.size(), typed ? typed_w : w);
    words_sent++;
    @(negedge clk);
  endtask

  // Hold off the sender until every word has come back and the block is idle
  task automatic drain();
    start <= 1'b0;
    @(negedge clk);
    while (expected_words.size() != 0 || busy) @(negedge clk);
  endtask

  task automatic write_count(int unsigned v);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v[10:0];
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    node_count = v & 11'h7FF;
  endtask

  // Result checker: every strobed word must match the oldest expectation
  always @(posedge clk) begin
    word_t w;
    if (rst_n && out_valid) begin
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word node=%0d status=%0d", $time, out_node, out_status);
        errors++;
      end else begin
        w = expected_words.pop_front();
        if (out_node !== w.node)
          $display("%0t: node mismatch expected %0d actual %0d", $time, w.node, out_node);
        if (out_status !== w.st)
          $display("%0t: status mismatch expected %0d actual %0d", $time, w.st, out_status);
        if (out_node !== w.node || out_status !== w.st) errors++;
      end
    end
  end

  // Watchdog: count cycles in which neither side moves a word
  int idle_cycles = 0;
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WD_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  localparam int DIR_N = 28;
  dir_row_t dir_tab [DIR_N] = '{
    '{ROW_WORD, CMD_POP,      11'd0,    1'b1, 10'd0, ST_OK},
    '{ROW_WORD, CMD_START,    11'd1023, 1'b1, 10'd0, ST_OK},
    '{ROW_WORD, CMD_CONTINUE, 11'd5,    1'b1, 10'd0, ST_OK},
    '{ROW_WORD, CMD_CONTINUE, 11'd5,    1'b1, 10'd0, ST_OK},   // self edge on 5
    '{ROW_WORD, CMD_POP,      11'd0,    1'b1, 10'd1, ST_OK},
    '{ROW_WORD, CMD_CLEAR,    11'd0,    1'b1, 10'd0, ST_OK},
    '{ROW_CFG,  CMD_CLEAR,    11'd3,    1'b0, 10'd0, ST_OK},
    '{ROW_WORD, CMD_START,    11'd3,    1'b1, 10'd0, ST_RANGE},
    '{ROW_WORD, CMD_CONTINUE, 11'd1023, 1'b1, 10'd0, ST_RANGE},
    '{ROW_WORD, CMD_START,    11'd2,    1'b1, 10'd0, ST_OK},
    '{ROW_WORD, CMD_CONTINUE, 11'd0,    1'b1, 10'd0, ST_OK},
    '{ROW_WORD, CMD_POP,      11'd0,    1'b1, 10'd1, ST_OK},
    '{ROW_WORD, CMD_POP,      11'd0,    1'b1, 10'd2, ST_OK},
    '{ROW_WORD, CMD_POP,      11'd0,    1'b1, 10'd0, ST_OK},
    '{ROW_WORD, CMD_POP,      11'd0,    1'b1, 10'd0, ST_COMPLETE},
    '{ROW_WORD, CMD_CLEAR,    11'd0,    1'b1, 10'd0, ST_OK},
    '{ROW_WORD, CMD_START,    11'd0,    1'b1, 10'd0, ST_OK},
    '{ROW_WORD, CMD_CONTINUE, 11'd1,    1'b1, 10'd0, ST_OK},
    '{ROW_WORD, CMD_CONTINUE, 11'd0,    1'b1, 10'd0, ST_OK},
    '{ROW_WORD, CMD_POP,      11'd0,    1'b1, 10'd2, ST_OK},
    '{ROW_WORD, CMD_POP,      11'd0,    1'b1, 10'd0, ST_CYCLE},
    '{ROW_CFG,  CMD_CLEAR,    11'd0,    1'b0, 10'd0, ST_OK},
    '{ROW_WORD, CMD_POP,      11'd0,    1'b1, 10'd0, ST_COMPLETE},
    '{ROW_CFG,  CMD_CLEAR,    11'd1024, 1'b0, 10'd0, ST_OK},
    '{ROW_WORD, CMD_START,    11'd900,  1'b1, 10'd0, ST_OK},
    '{ROW_CFG,  CMD_CLEAR,    11'd3,    1'b0, 10'd0, ST_OK},
    '{ROW_WORD, CMD_CONTINUE, 11'd1,    1'b1, 10'd0, ST_RANGE}, // remembered node now out of range
    '{ROW_CFG,  CMD_CLEAR,    11'd2047, 1'b0, 10'd0, ST_OK}
  };

  initial begin
    int unsigned live;
    int unsigned len;
    int unsigned pops;
    int unsigned nd;
    int unsigned pick_cfg;
    word_t none;
    none = '{node: '0, st: ST_OK};
    node_count = NODES;
    wipe_graph();

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);
    while (busy) @(negedge clk);

    // directed table
    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_CFG) write_count(dir_tab[i].arg);
      else send_word(dir_tab[i].cmd, dir_tab[i].arg, dir_tab[i].typed,
                     '{node: dir_tab[i].exp_node, st: dir_tab[i].exp_st});
    end
    send_word(CMD_POP, 0, 1'b0, none);   // count above the store size acts as full size

    // build one long random chain over the full node range, then take a few pops
    write_count(NODES);
    send_word(CMD_CLEAR, 0, 1'b0, none);
    send_word(CMD_START, 0, 1'b0, none);
    quiet = 1'b1;
    repeat (300) send_word(CMD_CONTINUE, $urandom_range(NODES - 1), 1'b0, none);
    quiet = 1'b0;
    repeat (6) send_word(CMD_POP, 0, 1'b0, none);

    // random phases: pick a size, build chains, pop until done or stuck
    while (words_sent < ITEMS) begin
      quiet = (words_sent > 600 && words_sent < 900);
      pick_cfg = $urandom_range(99);
      if (pick_cfg < 4) write_count(NODES);
      else if (pick_cfg < 7) write_count(2047);
      else if (pick_cfg < 9) write_count(0);
      else if (pick_cfg < 14) write_count(1);
      else write_count($urandom_range(2, 40));
      live = (node_count > NODES) ? NODES : node_count;
      send_word(CMD_CLEAR, 0, 1'b0, none);
      repeat ($urandom_range(1, 4)) begin
        send_word(CMD_START, (live == 0 || $urandom_range(9) == 0) ?
                  $urandom_range(NODES - 1) : $urandom_range(live - 1), 1'b0, none);
        len = $urandom_range(1, 8);
        repeat (len) begin
          nd = (live == 0 || $urandom_range(19) == 0) ?
               $urandom_range(NODES - 1) : $urandom_range(live - 1);
          send_word(CMD_CONTINUE, nd, 1'b0, none);
        end
        // now and then interleave a pop so later edges land on emitted nodes
        if ($urandom_range(4) == 0) send_word(CMD_POP, 0, 1'b0, none);
      end
      pops = (live > 48 ? 48 : live) + $urandom_range(1, 3);
      repeat (pops) begin
        if ($urandom_range(19) == 0) send_word(cmd_t'($urandom_range(3)),
                                               $urandom_range(NODES - 1), 1'b0, none);
        else send_word(CMD_POP, 0, 1'b0, none);
      end
    end

    drain();
    repeat (50) @(posedge clk);
    if (errors == 0 && expected_words.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
